### design/avskt_pkg.sv
package avskt_pkg;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned FP_W    = 20;
  localparam int unsigned COMP_W  = 15;
  localparam int unsigned HOLD_W  = 16;
  localparam int unsigned NOISE_W = 30;
  localparam int unsigned EST_W   = 25;
  localparam int unsigned COV_W   = 32;
  localparam int unsigned DUR_W   = 21;
  localparam int unsigned DELTA_W = 13;
  localparam int unsigned K_W     = 31;
  localparam int unsigned PN_W    = 33;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned EMAG_W  = 25;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 31;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned DIV_LO_W  = 33;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned ADJ_W   = 26;
  localparam int unsigned SAMP_W  = 64;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned FP_RESET     = 40000;
  localparam int unsigned PNOISE_RESET = 10737;
  localparam int unsigned MNOISE_RESET = 10737418;
  localparam int unsigned ONE_Q30      = 32'h4000_0000;
  localparam int unsigned Q30_SHIFT    = 30;
  localparam longint unsigned HALF_Q30 = 64'h2000_0000;
  localparam int          OFFSET_LIMIT = 10000000;
  localparam int unsigned DELTA_LIMIT  = 5000;
  localparam int unsigned DURATION_MAX = 1048575;
  localparam int unsigned US_PER_MS    = 1000;
  localparam int unsigned SQ_SCALE     = 1000000;
  localparam longint unsigned SQ_CAP   = 64'd5001000000;
  // divide by 10^6 as a shift by 6, then times ceil(2^41 / 15625) and a shift by 41
  localparam int unsigned SQ_PRE_SHIFT   = 6;
  localparam int unsigned SQ_RECIP       = 140737489;
  localparam int unsigned SQ_RECIP_SHIFT = 41;
  localparam int unsigned K_ITERS      = 31;

  typedef enum logic [2:0] {
    REG_FRAME_PERIOD = 3'd0,
    REG_AV_COMP      = 3'd1,
    REG_HOLDOFF      = 3'd2,
    REG_PROC_NOISE   = 3'd3,
    REG_MEAS_NOISE   = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_MUL,
    S_SQ_CHK,
    S_SQ_SCALE,
    S_DUR,
    S_DECIDE,
    S_K_DIV,
    S_CORR_MUL,
    S_CORR,
    S_COV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_RECIP,
    MUL_CORR,
    MUL_COV
  } mul_sel_t;

  typedef struct packed {
    logic [FP_W-1:0]          frame_period_us;
    logic signed [COMP_W-1:0] av_compensation_ms;
    logic [HOLD_W-1:0]        holdoff_frames;
    logic [NOISE_W-1:0]       process_noise;
    logic [NOISE_W-1:0]       measurement_noise;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic [HOLD_W-1:0] value;
  } hold_wr_t;

  typedef struct packed {
    logic     load_in;
    logic     z_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_k;
    logic     delta_cap;
    logic     delta_load;
    logic     dur_en;
    logic     pn_en;
    logic     k_clear;
    logic     k_load;
    logic     est_upd;
    logic     cov_upd;
    logic     restart;
    logic     holdoff_dec;
    logic     upd_clr;
    logic     upd_set;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic sq_big;
    logic div_busy;
    logic audio_ok;
    logic pts_ok;
    logic holdoff_nz;
    logic in_range;
    logic den_zero;
    logic out_free;
  } stat_t;

endpackage

### design/avskt_regs.sv
module avskt_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [avskt_pkg::ADDR_W-1:0]       paddr,
  input  logic [avskt_pkg::DATA_W-1:0]       pwdata,
  output logic [avskt_pkg::DATA_W-1:0]       prdata,
  output logic                               pready,
  output avskt_pkg::cfg_t                    cfg,
  output avskt_pkg::hold_wr_t                hold_wr
);

  logic                  wr;
  avskt_pkg::reg_idx_t   idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = avskt_pkg::reg_idx_t'(paddr[avskt_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period_us    <= avskt_pkg::FP_W'(avskt_pkg::FP_RESET);
      cfg.av_compensation_ms <= '0;
      cfg.holdoff_frames     <= '0;
      cfg.process_noise      <= avskt_pkg::NOISE_W'(avskt_pkg::PNOISE_RESET);
      cfg.measurement_noise  <= avskt_pkg::NOISE_W'(avskt_pkg::MNOISE_RESET);
    end else if (wr) begin
      case (idx)
        avskt_pkg::REG_FRAME_PERIOD: begin
          cfg.frame_period_us <= pwdata[avskt_pkg::FP_W-1:0];
        end
        avskt_pkg::REG_AV_COMP: begin
          cfg.av_compensation_ms <= $signed(pwdata[avskt_pkg::COMP_W-1:0]);
        end
        avskt_pkg::REG_HOLDOFF: begin
          cfg.holdoff_frames <= pwdata[avskt_pkg::HOLD_W-1:0];
        end
        avskt_pkg::REG_PROC_NOISE: begin
          cfg.process_noise <= pwdata[avskt_pkg::NOISE_W-1:0];
        end
        avskt_pkg::REG_MEAS_NOISE: begin
          cfg.measurement_noise <= pwdata[avskt_pkg::NOISE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // a holdoff write also reloads the frame counter
  always_comb begin
    hold_wr.load  = wr && (idx == avskt_pkg::REG_HOLDOFF);
    hold_wr.value = pwdata[avskt_pkg::HOLD_W-1:0];
  end

  always_comb begin
    case (idx)
      avskt_pkg::REG_FRAME_PERIOD: prdata = avskt_pkg::DATA_W'(cfg.frame_period_us);
      avskt_pkg::REG_AV_COMP:
        prdata = avskt_pkg::DATA_W'($unsigned(cfg.av_compensation_ms));
      avskt_pkg::REG_HOLDOFF:      prdata = avskt_pkg::DATA_W'(cfg.holdoff_frames);
      avskt_pkg::REG_PROC_NOISE:   prdata = avskt_pkg::DATA_W'(cfg.process_noise);
      avskt_pkg::REG_MEAS_NOISE:   prdata = avskt_pkg::DATA_W'(cfg.measurement_noise);
      default:                     prdata = '0;
    endcase
  end

endmodule

### design/avskt_div.sv
module avskt_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [avskt_pkg::DEN_W-1:0]           rem_init,
  input  logic [avskt_pkg::DIV_LO_W-1:0]        lo_init,
  input  logic [avskt_pkg::DEN_W-1:0]           den,
  input  logic [avskt_pkg::DIV_CNT_W-1:0]       iters,
  output logic                                  busy,
  output logic [avskt_pkg::DIV_LO_W-1:0]        quot
);

  logic [avskt_pkg::DIV_CNT_W-1:0]  cnt;
  logic [avskt_pkg::DEN_W-1:0]      rem;
  logic [avskt_pkg::DEN_W-1:0]      den_q;
  logic [avskt_pkg::DIV_LO_W-1:0]   lo;
  logic [avskt_pkg::DEN_W:0]        rem_sh;
  logic [avskt_pkg::DEN_W:0]        rem_sub;
  logic                             fits;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem, lo[avskt_pkg::DIV_LO_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == avskt_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      lo    <= lo_init;
      den_q <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sub[avskt_pkg::DEN_W-1:0] : rem_sh[avskt_pkg::DEN_W-1:0];
      lo   <= {lo[avskt_pkg::DIV_LO_W-2:0], 1'b0};
      quot <= {quot[avskt_pkg::DIV_LO_W-2:0], fits};
    end
  end

endmodule

### design/avskt_dp.sv
module avskt_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  avskt_pkg::cmd_t                       cmd,
  output avskt_pkg::stat_t                      stat,
  input  avskt_pkg::cfg_t                       cfg,
  input  avskt_pkg::hold_wr_t                   hold_wr,
  input  logic [avskt_pkg::IN_DATA_W-1:0]       s_tdata,
  input  logic [avskt_pkg::IN_USER_W-1:0]       s_tuser,
  input  logic                                  m_tready,
  output logic                                  m_tvalid,
  output logic [avskt_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic [0:0]                            m_tuser
);

  localparam int unsigned SW = avskt_pkg::SAMP_W;
  localparam int unsigned EW = avskt_pkg::EST_W;

  // item and intermediate registers
  logic                               audio_ok;
  logic                               pts_ok;
  logic signed [SW:0]                 diff_ap;
  logic signed [EW-1:0]               z;
  logic                               in_range;
  logic [avskt_pkg::PROD_W-1:0]       prod;
  logic [avskt_pkg::DELTA_W-1:0]      delta;
  logic signed [avskt_pkg::DUR_W-1:0] dur;
  logic [avskt_pkg::PN_W-1:0]         pn;
  logic [avskt_pkg::DEN_W-1:0]        den;
  logic [avskt_pkg::EMAG_W-1:0]       e_mag;
  logic                               e_neg;
  logic [avskt_pkg::K_W-1:0]          k;
  logic                               upd;

  // filter state
  logic signed [EW-1:0]               est;
  logic [avskt_pkg::COV_W-1:0]        cov;
  logic [avskt_pkg::HOLD_W-1:0]       holdoff_cnt;

  // combinational terms
  logic signed [avskt_pkg::ADJ_W-1:0] comp_ext;
  logic signed [avskt_pkg::ADJ_W-1:0] comp_us;
  logic signed [avskt_pkg::ADJ_W-1:0] fp2;
  logic signed [avskt_pkg::ADJ_W-1:0] adj;
  logic signed [SW+1:0]               z_full;
  logic                               z_in;
  logic [avskt_pkg::MAG_W-1:0]        est_mag;
  logic [avskt_pkg::MUL_A_W-1:0]      mul_a;
  logic [avskt_pkg::MUL_B_W-1:0]      mul_b;
  logic [avskt_pkg::PROD_W-1:0]       prod_c;
  logic signed [avskt_pkg::DUR_W:0]   dur_sum;
  logic signed [avskt_pkg::DUR_W:0]   delta_s;
  logic [avskt_pkg::PN_W-1:0]         pn_c;
  logic signed [EW:0]                 e_diff;
  logic [avskt_pkg::PROD_W-1:0]       corr_sum;
  logic [EW:0]                        corr;
  logic signed [EW+1:0]               est_sum;
  logic signed [EW-1:0]               est_next;
  logic [avskt_pkg::PROD_W:0]         p_sum;
  logic [avskt_pkg::PROD_W-avskt_pkg::Q30_SHIFT:0] p_val;
  logic                               div_start;
  logic [avskt_pkg::DEN_W-1:0]        div_rem;
  logic [avskt_pkg::DIV_LO_W-1:0]     div_lo;
  logic [avskt_pkg::DEN_W-1:0]        div_den;
  logic [avskt_pkg::DIV_CNT_W-1:0]    div_iters;
  logic                               div_busy;
  logic [avskt_pkg::DIV_LO_W-1:0]     div_q;

  // measured offset: audio minus pts, plus two periods, minus compensation
  always_comb begin
    comp_ext = {{(avskt_pkg::ADJ_W-avskt_pkg::COMP_W){cfg.av_compensation_ms[
                avskt_pkg::COMP_W-1]}}, cfg.av_compensation_ms};
    comp_us  = comp_ext * avskt_pkg::ADJ_W'(avskt_pkg::US_PER_MS);
    fp2      = $signed({{(avskt_pkg::ADJ_W-avskt_pkg::FP_W-1){1'b0}},
                        cfg.frame_period_us, 1'b0});
    adj      = fp2 - comp_us;
    z_full   = {diff_ap[SW], diff_ap} + {{(SW+2-avskt_pkg::ADJ_W){adj[avskt_pkg::ADJ_W-1]}}, adj};
    z_in     = (z_full < (SW+2)'(avskt_pkg::OFFSET_LIMIT)) &&
               (z_full > -((SW+2)'(avskt_pkg::OFFSET_LIMIT)));
  end

  assign est_mag = est[EW-1] ? avskt_pkg::MAG_W'(-est) : avskt_pkg::MAG_W'(est);

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      avskt_pkg::MUL_SQ: begin
        mul_a = avskt_pkg::MUL_A_W'(est_mag);
        mul_b = avskt_pkg::MUL_B_W'(est_mag);
      end
      avskt_pkg::MUL_RECIP: begin
        mul_a = avskt_pkg::MUL_A_W'(prod >> avskt_pkg::SQ_PRE_SHIFT);
        mul_b = avskt_pkg::MUL_B_W'(avskt_pkg::SQ_RECIP);
      end
      avskt_pkg::MUL_CORR: begin
        mul_a = avskt_pkg::MUL_A_W'(e_mag);
        mul_b = k;
      end
      avskt_pkg::MUL_COV: begin
        mul_a = pn;
        mul_b = avskt_pkg::MUL_B_W'(avskt_pkg::ONE_Q30) - k;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_c = avskt_pkg::PROD_W'(mul_a) * avskt_pkg::PROD_W'(mul_b);
  end

  // output duration, covariance prediction, innovation
  always_comb begin
    delta_s  = $signed({{(avskt_pkg::DUR_W+1-avskt_pkg::DELTA_W){1'b0}}, delta});
    dur_sum  = $signed({2'b00, cfg.frame_period_us}) + (est[EW-1] ? -delta_s : delta_s);
    pn_c     = {1'b0, cov} + avskt_pkg::PN_W'(cfg.process_noise);
    e_diff   = {z[EW-1], z} - {est[EW-1], est};
  end

  // state update from the product register
  always_comb begin
    corr_sum = prod + avskt_pkg::HALF_Q30;
    corr     = corr_sum[avskt_pkg::Q30_SHIFT+EW:avskt_pkg::Q30_SHIFT];
    est_sum  = {{2{est[EW-1]}}, est} +
               (e_neg ? -$signed({1'b0, corr}) : $signed({1'b0, corr}));
    if (est_sum > (EW+2)'(avskt_pkg::OFFSET_LIMIT)) begin
      est_next = EW'(avskt_pkg::OFFSET_LIMIT);
    end else if (est_sum < -((EW+2)'(avskt_pkg::OFFSET_LIMIT))) begin
      est_next = -(EW'(avskt_pkg::OFFSET_LIMIT));
    end else begin
      est_next = est_sum[EW-1:0];
    end
    p_sum = {1'b0, prod} + (avskt_pkg::PROD_W+1)'(avskt_pkg::HALF_Q30);
    p_val = p_sum[avskt_pkg::PROD_W:avskt_pkg::Q30_SHIFT];
  end

  // gain divider: pn shifted up by 30 over pn plus r
  always_comb begin
    div_start = cmd.div_k;
    div_rem   = avskt_pkg::DEN_W'(pn >> 1);
    div_lo    = {pn[0], {(avskt_pkg::DIV_LO_W-1){1'b0}}};
    div_den   = den;
    div_iters = avskt_pkg::DIV_CNT_W'(avskt_pkg::K_ITERS);
  end

  avskt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .lo_init  (div_lo),
    .den      (div_den),
    .iters    (div_iters),
    .busy     (div_busy),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      audio_ok <= s_tuser[0];
      pts_ok   <= s_tuser[1];
      diff_ap  <= $signed({s_tdata[SW-1], s_tdata[SW-1:0]}) -
                  $signed({s_tdata[2*SW-1], s_tdata[2*SW-1:SW]});
    end
    if (cmd.z_en) begin
      z        <= z_full[EW-1:0];
      in_range <= z_in;
    end
    if (cmd.mul_en) begin
      prod <= prod_c;
    end
    if (cmd.delta_cap) begin
      delta <= avskt_pkg::DELTA_W'(avskt_pkg::DELTA_LIMIT);
    end else if (cmd.delta_load) begin
      delta <= prod[avskt_pkg::SQ_RECIP_SHIFT +: avskt_pkg::DELTA_W];
    end
    if (cmd.dur_en) begin
      if (dur_sum > $signed((avskt_pkg::DUR_W+1)'(avskt_pkg::DURATION_MAX))) begin
        dur <= avskt_pkg::DUR_W'(avskt_pkg::DURATION_MAX);
      end else begin
        dur <= dur_sum[avskt_pkg::DUR_W-1:0];
      end
    end
    if (cmd.pn_en) begin
      pn    <= pn_c;
      den   <= {1'b0, pn_c} + avskt_pkg::DEN_W'(cfg.measurement_noise);
      e_neg <= e_diff[EW];
      e_mag <= e_diff[EW] ? avskt_pkg::EMAG_W'(-e_diff) : avskt_pkg::EMAG_W'(e_diff);
    end
    if (cmd.k_clear) begin
      k <= '0;
    end else if (cmd.k_load) begin
      k <= div_q[avskt_pkg::K_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      est         <= '0;
      cov         <= avskt_pkg::COV_W'(avskt_pkg::ONE_Q30);
      holdoff_cnt <= '0;
      upd         <= 1'b0;
    end else begin
      if (cmd.restart) begin
        est <= '0;
        cov <= avskt_pkg::COV_W'(avskt_pkg::ONE_Q30);
      end else begin
        if (cmd.est_upd) begin
          est <= est_next;
        end
        if (cmd.cov_upd) begin
          cov <= (p_val > (avskt_pkg::PROD_W-avskt_pkg::Q30_SHIFT+1)'({avskt_pkg::COV_W{1'b1}}))
                 ? {avskt_pkg::COV_W{1'b1}} : p_val[avskt_pkg::COV_W-1:0];
        end
      end
      if (hold_wr.load) begin
        holdoff_cnt <= hold_wr.value;
      end else if (cmd.holdoff_dec) begin
        holdoff_cnt <= holdoff_cnt - 1'b1;
      end
      if (cmd.upd_clr) begin
        upd <= 1'b0;
      end else if (cmd.upd_set) begin
        upd <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{(avskt_pkg::OUT_DATA_W-avskt_pkg::DUR_W-EW){1'b0}}, est, dur};
      m_tuser <= upd;
    end
  end

  always_comb begin
    stat.sq_big     = prod >= avskt_pkg::SQ_CAP;
    stat.div_busy   = div_busy;
    stat.audio_ok   = audio_ok;
    stat.pts_ok     = pts_ok;
    stat.holdoff_nz = holdoff_cnt != '0;
    stat.in_range   = in_range;
    stat.den_zero   = den == '0;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

### design/avskt_ctrl.sv
module avskt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  avskt_pkg::stat_t  stat,
  output avskt_pkg::cmd_t   cmd
);

  avskt_pkg::state_t state;
  avskt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avskt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = avskt_pkg::MUL_SQ;
    s_tready    = 1'b0;
    case (state)
      avskt_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          cmd.upd_clr = 1'b1;
          state_next  = avskt_pkg::S_SQ_MUL;
        end
      end
      avskt_pkg::S_SQ_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = avskt_pkg::MUL_SQ;
        cmd.z_en    = 1'b1;
        state_next  = avskt_pkg::S_SQ_CHK;
      end
      avskt_pkg::S_SQ_CHK: begin
        if (stat.sq_big) begin
          cmd.delta_cap = 1'b1;
          state_next    = avskt_pkg::S_DUR;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = avskt_pkg::MUL_RECIP;
          state_next  = avskt_pkg::S_SQ_SCALE;
        end
      end
      avskt_pkg::S_SQ_SCALE: begin
        cmd.delta_load = 1'b1;
        state_next     = avskt_pkg::S_DUR;
      end
      avskt_pkg::S_DUR: begin
        cmd.dur_en = 1'b1;
        cmd.pn_en  = 1'b1;
        state_next = avskt_pkg::S_DECIDE;
      end
      avskt_pkg::S_DECIDE: begin
        if (!stat.pts_ok) begin
          state_next = avskt_pkg::S_OUT;
        end else if (!stat.audio_ok) begin
          cmd.restart = 1'b1;
          state_next  = avskt_pkg::S_OUT;
        end else if (stat.holdoff_nz) begin
          cmd.restart     = 1'b1;
          cmd.holdoff_dec = 1'b1;
          state_next      = avskt_pkg::S_OUT;
        end else if (!stat.in_range) begin
          state_next = avskt_pkg::S_OUT;
        end else if (stat.den_zero) begin
          cmd.k_clear = 1'b1;
          state_next  = avskt_pkg::S_CORR_MUL;
        end else begin
          cmd.div_k  = 1'b1;
          state_next = avskt_pkg::S_K_DIV;
        end
      end
      avskt_pkg::S_K_DIV: begin
        if (!stat.div_busy) begin
          cmd.k_load = 1'b1;
          state_next = avskt_pkg::S_CORR_MUL;
        end
      end
      avskt_pkg::S_CORR_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = avskt_pkg::MUL_CORR;
        state_next  = avskt_pkg::S_CORR;
      end
      avskt_pkg::S_CORR: begin
        cmd.est_upd = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = avskt_pkg::MUL_COV;
        state_next  = avskt_pkg::S_COV;
      end
      avskt_pkg::S_COV: begin
        cmd.cov_upd = 1'b1;
        cmd.upd_set = 1'b1;
        state_next  = avskt_pkg::S_OUT;
      end
      avskt_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = avskt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = avskt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/av_sync_kalman_tracker_unit.sv
// audio-video sync tracker, one word in and one word out per displayed frame.
// input stream (s_*): audio clock and frame pts in us with their valid flags.
// output stream (m_*): output duration from the estimate before the update,
// the filtered offset after it, and a flag set when the filter took a sample.
// apb port: frame period, compensation, holdoff frames, q and r registers at
// byte addresses 0, 4, 8, 12 and 16; a holdoff write also reloads the counter.
// one word is worked on at a time. the shortest pass, acceptance to result, is
// with the square already past its cap and no filter update, the longest with a
// full filter update; the controller returns to idle before the next word.
// the longest pass is set by the restoring divider for the gain, 31 steps at one
// bit per cycle; the squared offset is scaled by a reciprocal multiply.
// a finished result sits in the output register; the next word is accepted
// while it waits, and work stalls only at the end of a pass until the
// receiver has taken the previous result.
// reset clears the estimate, sets the covariance to one and restores the
// register defaults; no result is pending after reset.
module av_sync_kalman_tracker_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // audio_clock_us [63:0], pts_us [127:64]
  input  logic [avskt_pkg::IN_DATA_W-1:0]      s_tdata,
  // audio_clock_valid [0], pts_valid [1]
  input  logic [avskt_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // output_duration_us [20:0], filtered_offset_us [45:21], zero [47:46]
  output logic [avskt_pkg::OUT_DATA_W-1:0]     m_tdata,
  // filter_updated [0]
  output logic [0:0]                           m_tuser,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [avskt_pkg::ADDR_W-1:0]         paddr,
  input  logic [avskt_pkg::DATA_W-1:0]         pwdata,
  output logic [avskt_pkg::DATA_W-1:0]         prdata,
  output logic                                 pready
);

  avskt_pkg::cfg_t      cfg;
  avskt_pkg::hold_wr_t  hold_wr;
  avskt_pkg::cmd_t      cmd;
  avskt_pkg::stat_t     stat;

  avskt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .hold_wr (hold_wr)
  );

  avskt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  avskt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg      (cfg),
    .hold_wr  (hold_wr),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef ASSERT_OFF
  // a word in flight blocks the next one
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a word is in flight");

  // estimate stays inside its clamp
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[45:21]) <= 25'sd10000000) &&
                 ($signed(m_tdata[45:21]) >= -25'sd10000000))
    else $error("filtered offset outside clamp");

  // correction never pulls the duration below minus the cap
  a_dur_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[20:0]) >= -21'sd5000)
    else $error("output duration below lower bound");
`endif

endmodule
